// ----- rtl/core/modbus_frame_crc_checker_core_defines.svh -----
// Assertion macros shared by the frame checker RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef MODBUS_FRAME_CRC_CHECKER_CORE_DEFINES_SVH
`define MODBUS_FRAME_CRC_CHECKER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MFCC_ASSERT(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
`define MFCC_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define MFCC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define MFCC_ASSERT(label, clk, rst_n, cond)
`define MFCC_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define MFCC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- rtl/core/mfcc_pkg.sv -----
// Types, constants and the CRC-16 byte update for the frame checker.
// No dependencies; used by every module of the core.
package mfcc_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_EOF  = 1'b1
	} op_e_t;

	typedef struct packed {
		op_e_t      op;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [15:0] crc_value;
		logic [7:0]  frame_length;
		logic        frame_ok;
	} result_t;

	// Reflected CRC-16, one byte: eight shift/xor steps on 16 bits.
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/mfcc_front.sv -----
// Input stage: takes beats, tags each as a data byte or an end of frame.
// Depends on mfcc_pkg; feeds mfcc_queue.
module mfcc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,  // data_byte[7:0]
	input  logic                s_tuser,  // func: 0 byte, 1 end of frame
	output logic                push,
	output mfcc_pkg::item_t     push_item,
	input  logic                q_ready
);

	logic            valid_s1;
	mfcc_pkg::item_t item_s1;

	assign push      = valid_s1;
	assign push_item = item_s1;
	assign s_tready  = !valid_s1 || q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			if (s_tuser) begin
				item_s1.op   <= mfcc_pkg::OP_EOF;
				item_s1.data <= 8'h00;
			end else begin
				item_s1.op   <= mfcc_pkg::OP_BYTE;
				item_s1.data <= s_tdata;
			end
		end
	end

endmodule

// ----- rtl/core/mfcc_queue.sv -----
// Short FIFO of classified items between the input stage and the checker.
// Depends on mfcc_pkg and the assertion macro header.
`include "modbus_frame_crc_checker_core_defines.svh"
module mfcc_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mfcc_pkg::item_t push_item,
	output logic            q_ready,
	output logic            pop_valid,
	output mfcc_pkg::item_t pop_item,
	input  logic            pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	mfcc_pkg::item_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign q_ready   = (count_q != FULL_CNT);
	assign pop_valid = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];
	assign do_push   = push && q_ready;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`MFCC_ASSERT(a_count_bound, clk, arst_n, count_q <= FULL_CNT)
	`MFCC_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, pop, count_q != '0)
	`MFCC_ASSERT_NEXT(a_push_counts, clk, arst_n, do_push && !do_pop, count_q == $past(count_q) + 1'b1)

endmodule

// ----- rtl/core/mfcc_back.sv -----
// Frame state: running CRC, two held-back bytes, byte count, result register.
// Depends on mfcc_pkg and the assertion macro header.
`include "modbus_frame_crc_checker_core_defines.svh"
module mfcc_back #(
	parameter int MAX_FRAME = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	input  mfcc_pkg::item_t pop_item,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [31:0]     m_tdata  // frame_ok[0], frame_length[8:1], crc_value[24:9]
);

	localparam logic [7:0] MAX_CNT = 8'(MAX_FRAME);

	logic [15:0]       crc_q;
	logic [7:0]        older_q;
	logic [7:0]        newer_q;
	logic [7:0]        count_q;
	logic              out_valid_q;
	mfcc_pkg::result_t out_q;

	logic              is_eof;
	logic              slot_free;
	logic [15:0]       crc_sel;
	logic              ok;
	mfcc_pkg::result_t res;

	assign is_eof    = (pop_item.op == mfcc_pkg::OP_EOF);
	assign slot_free = !out_valid_q || m_tready;
	assign pop       = pop_valid && (!is_eof || slot_free);

	always_comb begin
		// two-byte frame: the CRC covers the first byte alone
		crc_sel = (count_q == 8'd2) ? mfcc_pkg::crc_fold(mfcc_pkg::CRC_INIT, older_q) : crc_q;
		if (count_q == 8'd1) begin
			crc_sel = mfcc_pkg::CRC_INIT;
			ok      = 1'b0;
		end else begin
			ok = (older_q == crc_sel[7:0]) && (newer_q == crc_sel[15:8]);
		end
		res.frame_ok     = ok;
		res.frame_length = ok ? count_q : 8'd0;
		res.crc_value    = crc_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= mfcc_pkg::CRC_INIT;
			older_q     <= 8'h00;
			newer_q     <= 8'h00;
			count_q     <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && is_eof && count_q != 8'd0) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (is_eof) begin
					crc_q   <= mfcc_pkg::CRC_INIT;
					older_q <= 8'h00;
					newer_q <= 8'h00;
					count_q <= 8'd0;
				end else if (count_q < MAX_CNT) begin
					if (count_q >= 8'd2) begin
						crc_q <= mfcc_pkg::crc_fold(crc_q, older_q);
					end
					older_q <= newer_q;
					newer_q <= pop_item.data;
					count_q <= count_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_eof && count_q != 8'd0) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q};

	`MFCC_ASSERT(a_count_max, clk, arst_n, count_q <= MAX_CNT)
	`MFCC_ASSERT_NEXT(a_eof_clears, clk, arst_n, pop && is_eof, count_q == 8'd0 && crc_q == mfcc_pkg::CRC_INIT)
	`MFCC_ASSERT_NEXT(a_eof_reports, clk, arst_n, pop && is_eof && count_q != 8'd0, m_tvalid)

endmodule

// ----- rtl/core/modbus_frame_crc_checker_core.sv -----
// Modbus RTU frame checker: CRC-16 (0xA001, init 0xFFFF) over a byte stream.
// Throughput: one beat per cycle, bytes and end-of-frame alike, unless an
// unread result holds back an end of frame. The CRC byte update is a single
// XOR network in the checker stage. An end-of-frame beat passes the input
// register and the queue, then the result register once the slot is free.
// Reset: asynchronous; clears the queue, the result slot and the frame state.
module modbus_frame_crc_checker_core #(
	parameter int MAX_FRAME   = 128,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte[7:0]
	input  logic        s_tuser,  // func: 0 byte, 1 end of frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // frame_ok[0], frame_length[8:1], crc_value[24:9]
);

	logic            push;
	mfcc_pkg::item_t push_item;
	logic            q_ready;
	logic            pop_valid;
	mfcc_pkg::item_t pop_item;
	logic            pop;

	mfcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready)
	);

	mfcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.q_ready   (q_ready),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop       (pop)
	);

	mfcc_back #(
		.MAX_FRAME (MAX_FRAME)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- dv/modbus_frame_report_checker.sv -----
`timescale 1ns / 100ps
// CRC helper for the frame checker bench, and the monitor that predicts and
// compares each frame report. Depends on mfcc_pkg from the RTL core.
package modbus_crc_tb_pkg;

	import mfcc_pkg::*;

	// Bit-serial form of the reflected CRC-16: one data bit at a time.
	function automatic logic [15:0] crc16_update(input logic [15:0] acc,
		input logic [7:0] octet);
		logic [15:0] r;
		logic fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ octet[i];
			r = r >> 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

endpackage

module modbus_frame_report_checker
	import mfcc_pkg::*;
	import modbus_crc_tb_pkg::*;
#(
	parameter int MAX_FRAME = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte[7:0]
	input  logic        s_tuser,   // func: 0 byte, 1 end of frame
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // frame_ok[0], frame_length[8:1], crc_value[24:9]
	output int          err_count,
	output int          pending,
	output int          reports_seen,
	output int          good_seen
);

	logic [15:0] crc_acc;
	logic [7:0]  older_byte;
	logic [7:0]  newer_byte;
	logic [7:0]  stored;
	result_t     rpt;
	result_t     want;
	result_t     expected_reports[$];

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_acc = CRC_INIT;
			older_byte = 8'h00;
			newer_byte = 8'h00;
			stored = 8'd0;
			expected_reports.delete();
			err_count = 0;
			reports_seen = 0;
			good_seen = 0;
			pending = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser == OP_BYTE) begin
					// bytes past a full frame are dropped
					if (stored < MAX_FRAME) begin
						if (stored >= 2) begin
							crc_acc = crc16_update(crc_acc, older_byte);
						end
						older_byte = newer_byte;
						newer_byte = s_tdata;
						stored = stored + 8'd1;
					end
				end else if (stored != 0) begin
					if (stored == 1) begin
						rpt.crc_value = CRC_INIT;
						rpt.frame_ok = 1'b0;
					end else begin
						// two-byte frame: CRC covers the first byte alone
						rpt.crc_value = (stored == 2) ? crc16_update(CRC_INIT, older_byte)
							: crc_acc;
						rpt.frame_ok = (older_byte == rpt.crc_value[7:0]) &&
							(newer_byte == rpt.crc_value[15:8]);
					end
					rpt.frame_length = rpt.frame_ok ? stored : 8'd0;
					expected_reports.push_back(rpt);
					crc_acc = CRC_INIT;
					older_byte = 8'h00;
					newer_byte = 8'h00;
					stored = 8'd0;
				end
			end
			if (m_tvalid && m_tready) begin
				reports_seen++;
				if (expected_reports.size() == 0) begin
					err_count++;
					$display("%0t: unexpected report beat, got ok=%0d len=%0d crc=%h",
						$time, m_tdata[0], m_tdata[8:1], m_tdata[24:9]);
				end else begin
					want = expected_reports.pop_front();
					if (want.frame_ok) begin
						good_seen++;
					end
					if (want.frame_ok !== m_tdata[0] || want.frame_length !== m_tdata[8:1] ||
						want.crc_value !== m_tdata[24:9]) begin
						err_count++;
						$display("%0t: report mismatch, expected ok=%0d len=%0d crc=%h, got ok=%0d len=%0d crc=%h",
							$time, want.frame_ok, want.frame_length, want.crc_value,
							m_tdata[0], m_tdata[8:1], m_tdata[24:9]);
					end
				end
			end
			pending = expected_reports.size();
		end
	end

endmodule

// ----- dv/modbus_frame_crc_checker_core_test.sv -----
`timescale 1ns / 100ps
// Top of the frame checker bench: clock, reset, byte/end-of-frame stimulus
// and verdict. Depends on mfcc_pkg, the core RTL and modbus_frame_report_checker.
module modbus_frame_crc_checker_core_test;

	import mfcc_pkg::*;
	import modbus_crc_tb_pkg::*;

	localparam int MAX_FRAME = 128;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BEATS = 545;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int beats_sent = 0;
	int cycle_count = 0;
	int err_count;
	int pending_reports;
	int reports_seen;
	int good_seen;

	modbus_frame_crc_checker_core #(.MAX_FRAME(MAX_FRAME)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	modbus_frame_report_checker #(.MAX_FRAME(MAX_FRAME)) report_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.err_count    (err_count),
		.pending      (pending_reports),
		.reports_seen (reports_seen),
		.good_seen    (good_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d reports outstanding", $time, pending_reports);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_beat(input op_e_t op, input logic [7:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'($urandom);
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic send_frame(input logic [7:0] body[$], input bit with_crc,
		input bit corrupt);
		logic [15:0] acc;
		int pos;
		acc = CRC_INIT;
		foreach (body[i]) acc = crc16_update(acc, body[i]);
		if (with_crc) begin
			body.push_back(acc[7:0]);
			body.push_back(acc[15:8]);
		end
		if (corrupt && body.size() > 0) begin
			pos = $urandom_range(body.size() - 1);
			body[pos] = body[pos] ^ 8'(1 << $urandom_range(7));
		end
		foreach (body[i]) send_beat(OP_BYTE, body[i]);
		send_beat(OP_EOF, 8'($urandom));
	endtask

	task automatic run_phase(input int n_beats);
		logic [7:0] body[$];
		int stop_at;
		int k;
		int len;
		bit first;
		stop_at = beats_sent + n_beats;
		first = 1'b1;
		while (beats_sent < stop_at) begin
			k = first ? 0 : $urandom_range(99);
			first = 1'b0;
			body.delete();
			if (k < 2) begin
				// near or past a full frame, CRC appended or not
				len = $urandom_range(MAX_FRAME - 6, MAX_FRAME + 4);
				repeat (len) body.push_back(8'($urandom));
				send_frame(body, $urandom_range(1), 1'b0);
			end else if (k < 65) begin
				len = $urandom_range(1, 12);
				repeat (len) body.push_back(8'($urandom));
				send_frame(body, 1'b1, 1'b0);
			end else if (k < 82) begin
				len = $urandom_range(1, 12);
				repeat (len) body.push_back(8'($urandom));
				send_frame(body, 1'b1, 1'b1);
			end else if (k < 92) begin
				len = $urandom_range(0, 4);
				repeat (len) body.push_back(8'($urandom));
				send_frame(body, 1'b0, 1'b0);
			end else begin
				repeat ($urandom_range(1, 6)) send_beat(op_e_t'($urandom_range(1)), 8'($urandom));
			end
			if ($urandom_range(39) == 0) begin
				s_tvalid <= 1'b0;
				wait (pending_reports == 0);
				@(negedge clk);
			end
		end
	endtask

	initial begin
		logic [7:0] body[$];
		logic [15:0] t;
		int pair_byte;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = 8'h00;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty, single byte, two-byte frames, good and corrupted frames
		send_beat(OP_EOF, 8'hFF);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_EOF, 8'h00);
		pair_byte = -1;
		for (int v = 0; v < 256; v++) begin
			t = crc16_update(CRC_INIT, 8'(v));
			if (pair_byte < 0 && t[7:0] == 8'(v)) begin
				pair_byte = v;
			end
		end
		if (pair_byte >= 0) begin
			t = crc16_update(CRC_INIT, 8'(pair_byte));
			send_beat(OP_BYTE, 8'(pair_byte));
			send_beat(OP_BYTE, t[15:8]);
			send_beat(OP_EOF, 8'h00);
		end
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_EOF, 8'hFF);
		body = {8'h00, 8'hFF};
		send_frame(body, 1'b1, 1'b0);
		body = {8'hA5};
		send_frame(body, 1'b1, 1'b1);

		// hold off until the directed reports are all back
		s_tvalid <= 1'b0;
		wait (pending_reports == 0);
		@(negedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 48;
		run_phase(PHASE_BEATS);
		send_idle_pct = 48;
		recv_idle_pct = 33;
		run_phase(PHASE_BEATS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(PHASE_BEATS);

		s_tvalid <= 1'b0;
		wait (pending_reports == 0);
		repeat (8) @(posedge clk);

		$display("Sent %0d beats over three stall mixes, incl. overfull, short and corrupted frames.",
			beats_sent);
		$display("Checked %0d frame reports, %0d of them with a matching CRC.",
			reports_seen, good_seen);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mfcc_pkg.sv
rtl/core/mfcc_front.sv
rtl/core/mfcc_queue.sv
rtl/core/mfcc_back.sv
rtl/core/modbus_frame_crc_checker_core.sv
dv/modbus_frame_report_checker.sv
dv/modbus_frame_crc_checker_core_test.sv
